// ===== rtl/core/pomlm_pkg.sv =====
// ----------------------------------------------------------------------------
// pomlm_pkg: shared types and constants of the overlay mixer and level meter
// Holds the item structs, item kinds, register indexes, the controller
// state type and the 16-bit saturation helper.
// ----------------------------------------------------------------------------
package pomlm_pkg;

  // Overlay store geometry.
  localparam int OVERLAY_DEPTH = 16384;
  localparam int IDX_W         = $clog2(OVERLAY_DEPTH);
  localparam int LEN_W         = IDX_W + 1;

  // Level meter window.
  localparam int LEVEL_WINDOW  = 512;
  localparam int WIN_W         = $clog2(LEVEL_WINDOW);
  localparam int SUM_W         = 16 + WIN_W;

  // Fixed-point scaling shifts.
  localparam int OVL_SHIFT     = 8;
  localparam int GAIN_SHIFT    = 6;

  // Width of the products and sums ahead of saturation.
  localparam int WIDE_W        = 25;

  // Configuration port.
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  // Register reset values.
  localparam logic [31:0] STEP_RESET  = 32'd65536;
  localparam logic [7:0]  GAIN_RESET  = 8'd64;
  localparam logic [7:0]  SCALE_RESET = 8'd230;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP = 2'd0,
    CFG_GAIN = 2'd1,
    CFG_MONO = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_START = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] in_left;
    logic signed [15:0] in_right;
    logic [IDX_W-1:0]   store_index;
    logic signed [15:0] store_value;
    logic [LEN_W-1:0]   overlay_length;
    logic [7:0]         overlay_gain;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               overlay_busy;
    logic [15:0]        level;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_AMP,
    ST_LOAD
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;
    logic mix;
    logic amp;
    logic load;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;
  } dp_status_t;

  // Clamp a wide signed value to the 16-bit sample range.
  function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32767);
    lo = -WIDE_W'(32768);
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// ===== rtl/core/pomlm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pomlm_ctrl: sequencer of the overlay mixer
// Takes items in idle, walks a media frame through the mix, gain and load
// steps, and holds the load step until the output register is free.
// ----------------------------------------------------------------------------
module pomlm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  pomlm_pkg::kind_t      in_kind,
  output logic                  in_stall,
  input  pomlm_pkg::dp_status_t status,
  output pomlm_pkg::dp_cmd_t    cmd
);
  import pomlm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state. Only media frames leave idle; other kinds finish on the take.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_kind == KIND_FRAME)) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX:  state_nxt = ST_AMP;
      ST_AMP:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (status.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_MIX:  cmd.mix = 1'b1;
      ST_AMP:  cmd.amp = 1'b1;
      ST_LOAD: cmd.load = status.slot_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/pomlm_dp.sv =====
// ----------------------------------------------------------------------------
// pomlm_dp: datapath of the overlay mixer and level meter
// Holds the configuration registers, the overlay store, the overlay playhead
// state, the mix and gain arithmetic, the level meter and the output register.
// ----------------------------------------------------------------------------
module pomlm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pomlm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pomlm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  pomlm_pkg::in_item_t                  in_data,
  output pomlm_pkg::out_item_t                 out_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  input  pomlm_pkg::dp_cmd_t                   cmd,
  output pomlm_pkg::dp_status_t                status
);
  import pomlm_pkg::*;

  // Configuration registers.
  logic [31:0] step_r;
  logic [7:0]  gain_r;
  logic        mono_r;

  // Overlay state.
  logic [31:0]      playhead_r;
  logic [31:0]      playhead_nxt;
  logic             on_r;
  logic             on_nxt;
  logic [LEN_W-1:0] count_r;
  logic [LEN_W-1:0] count_nxt;
  logic [7:0]       scale_r;
  logic [7:0]       scale_nxt;

  // Overlay store.
  logic signed [15:0] mem [OVERLAY_DEPTH];
  logic signed [15:0] rd_r;

  // Sample pipeline.
  logic signed [15:0]       l_r;
  logic signed [15:0]       r_r;
  logic signed [WIDE_W-1:0] pl_r;
  logic signed [WIDE_W-1:0] pr_r;

  // Level meter.
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [WIN_W-1:0] win_r;
  logic [WIN_W-1:0] win_nxt;
  logic [15:0]      level_r;
  logic [15:0]      level_nxt;

  // Output register.
  out_item_t out_r;
  logic      out_valid_r;

  // Mix and meter intermediate values.
  logic [15:0]              ph_int;
  logic                     mix_ok;
  logic signed [WIDE_W-1:0] ovl_prod;
  logic signed [WIDE_W-1:0] ovl_add;
  logic signed [15:0]       mix_l;
  logic signed [15:0]       mix_r;
  logic signed [15:0]       amp_l;
  logic signed [15:0]       amp_r;
  logic [15:0]              mag;
  logic [SUM_W-1:0]         sum_acc;
  logic [LEN_W-1:0]         start_len;

  // Configuration writes; an unused index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      gain_r <= GAIN_RESET;
      mono_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP: step_r <= cfg_data[31:0];
        CFG_GAIN: gain_r <= cfg_data[7:0];
        CFG_MONO: mono_r <= cfg_data[0];
        CFG_NONE: ;
        default:  ;
      endcase
    end
  end

  // Store write port and registered read at the playhead index.
  assign ph_int = playhead_r[31:16];

  always_ff @(posedge clk) begin
    if (cmd.take && (in_data.kind == KIND_WRITE)) begin
      mem[in_data.store_index] <= in_data.store_value;
    end
    if (cmd.take) begin
      rd_r <= mem[ph_int[IDX_W-1:0]];
    end
  end

  // Overlay scaling and saturating add onto both channels.
  assign mix_ok   = on_r && ({1'b0, ph_int} < {{(17 - LEN_W){1'b0}}, count_r});
  assign ovl_prod = WIDE_W'($signed(rd_r) * $signed({1'b0, scale_r}));
  assign ovl_add  = ovl_prod >>> OVL_SHIFT;
  assign mix_l    = sat16(WIDE_W'(l_r) + ovl_add);
  assign mix_r    = sat16(WIDE_W'(r_r) + ovl_add);

  // A start longer than the store is clamped to its depth.
  assign start_len = (in_data.overlay_length > LEN_W'(OVERLAY_DEPTH)) ?
                     LEN_W'(OVERLAY_DEPTH) : in_data.overlay_length;

  // Overlay state next values.
  always_comb begin
    playhead_nxt = playhead_r;
    on_nxt       = on_r;
    count_nxt    = count_r;
    scale_nxt    = scale_r;
    if (cmd.take) begin
      unique case (in_data.kind)
        KIND_START: begin
          if (in_data.overlay_length != '0) begin
            playhead_nxt = '0;
            on_nxt       = 1'b1;
            count_nxt    = start_len;
            scale_nxt    = in_data.overlay_gain;
          end
        end
        KIND_STOP:  on_nxt = 1'b0;
        KIND_FRAME: ;
        KIND_WRITE: ;
        default:    ;
      endcase
    end else if (cmd.mix) begin
      if (mix_ok) begin
        playhead_nxt = playhead_r + step_r;
      end else begin
        on_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playhead_r <= '0;
      on_r       <= 1'b0;
      count_r    <= '0;
      scale_r    <= SCALE_RESET;
    end else begin
      playhead_r <= playhead_nxt;
      on_r       <= on_nxt;
      count_r    <= count_nxt;
      scale_r    <= scale_nxt;
    end
  end

  // Sample pipeline: latch the frame, mix, then apply the master gain.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      l_r <= in_data.in_left;
      r_r <= mono_r ? in_data.in_left : in_data.in_right;
    end else if (cmd.mix && mix_ok) begin
      l_r <= mix_l;
      r_r <= mix_r;
    end
    if (cmd.amp) begin
      pl_r <= WIDE_W'($signed(l_r) * $signed({1'b0, gain_r}));
      pr_r <= WIDE_W'($signed(r_r) * $signed({1'b0, gain_r}));
    end
  end

  // Gain shift and saturation, then the meter over the amplified left sample.
  assign amp_l   = sat16(pl_r >>> GAIN_SHIFT);
  assign amp_r   = sat16(pr_r >>> GAIN_SHIFT);
  assign mag     = amp_l[15] ? (~amp_l + 16'd1) : amp_l;
  assign sum_acc = sum_r + {{WIN_W{1'b0}}, mag};

  always_comb begin
    sum_nxt   = sum_r;
    win_nxt   = win_r;
    level_nxt = level_r;
    if (cmd.load) begin
      if (win_r == WIN_W'(LEVEL_WINDOW - 1)) begin
        level_nxt = sum_acc[WIN_W +: 16];
        sum_nxt   = '0;
        win_nxt   = '0;
      end else begin
        sum_nxt   = sum_acc;
        win_nxt   = win_r + WIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      win_r   <= '0;
      level_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      win_r   <= win_nxt;
      level_r <= level_nxt;
    end
  end

  // Output register; it frees when its beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.out_left     <= amp_l;
      out_r.out_right    <= amp_r;
      out_r.overlay_busy <= on_r;
      out_r.level        <= level_nxt;
    end
  end

  assign status.slot_free = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

// ===== rtl/core/pcm_overlay_mixer_level_meter_unit.sv =====
// ----------------------------------------------------------------------------
// pcm_overlay_mixer_level_meter_unit: stereo mixer with overlay and meter
// Mixes a resampled overlay stream onto media frames, applies a master gain
// and reports a windowed mean of the left level.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                           Moves
//   input    in_valid, in_stall, in_data     one item beat (frame or command)
//   output   out_valid, out_stall, out_data  one result beat per media frame
//   config   cfg_we, cfg_index, cfg_data     one register write, no wait
//
// A media frame passes through the take with the store read, the overlay
// mix, the gain multiply and the output load. Store writes, starts and stops
// finish on the take. The output register lets the next item be taken while
// a result beat is still stalled; a frame waits in its load step only while
// that register is full and stalled. Reset is synchronous and needs no
// clearing pass; store entries are undefined until written.
//
module pcm_overlay_mixer_level_meter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pomlm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pomlm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pomlm_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pomlm_pkg::out_item_t              out_data
);
  import pomlm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  pomlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  pomlm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef NO_ASSERTIONS
  // A media frame beat holds off the input for its work.
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.kind == KIND_FRAME)) |=> in_stall)
    else $error("input not stalled after a frame beat");

  // Commands finish on the take and leave the input open.
  a_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.kind != KIND_FRAME)) |=> !in_stall)
    else $error("input stalled after a command beat");

  // A frame releases the input only once its result sits in the output register.
  a_done_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("frame finished without a result beat");

  // A frame beat is followed, at its load step, by a stalled input or a pending result.
  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.kind == KIND_FRAME)) |=> ##2 (in_stall || out_valid))
    else $error("frame result missing");
`endif

endmodule

// ===== bench/pcm_overlay_mixer_level_meter_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_overlay_mixer_level_meter_unit_test: self-checking bench for the mixer
// Sends media frames, overlay store writes, overlay starts and stops under
// several register settings. Both channels idle at random. A mirror of the
// mixer predicts each result beat, and the beats are checked in order.
// ----------------------------------------------------------------------------
module pcm_overlay_mixer_level_meter_unit_test;
  import pomlm_pkg::*;

  // Quiet cycles that let a command with no result beat leave the block.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  bit          idle_on    = 1'b1;
  int          stall_left = 0;
  int unsigned fail_count = 0;

  // Expected result beats, oldest first.
  out_item_t   expected_frames[$];

  // Mirror of the mixer state and its registers.
  logic signed [15:0] ovl_mem [OVERLAY_DEPTH];
  bit                 ovl_written [OVERLAY_DEPTH];
  logic [31:0]        ph_acc;
  bit                 ovl_active;
  int unsigned        ovl_len;
  logic [7:0]         ovl_gain_q;
  int unsigned        lvl_acc;
  int unsigned        lvl_frames;
  logic [15:0]        lvl_mean;
  logic [31:0]        step_q;
  logic [7:0]         gain_q;
  bit                 mono_q;

  pcm_overlay_mixer_level_meter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Back-pressure on the result channel in random bursts.
  always @(posedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 17);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_frames.size() == 0) begin
        note_failure($sformatf("unexpected result beat: L=%0d R=%0d busy=%0b level=%0d",
                               $signed(out_data.out_left), $signed(out_data.out_right),
                               out_data.overlay_busy, out_data.level));
      end else begin
        want = expected_frames.pop_front();
        if (out_data.out_left !== want.out_left || out_data.out_right !== want.out_right ||
            out_data.overlay_busy !== want.overlay_busy || out_data.level !== want.level) begin
          note_failure({$sformatf("frame mismatch: expected L=%0d R=%0d busy=%0b level=%0d",
                                  $signed(want.out_left), $signed(want.out_right),
                                  want.overlay_busy, want.level),
                        $sformatf(", got L=%0d R=%0d busy=%0b level=%0d",
                                  $signed(out_data.out_left), $signed(out_data.out_right),
                                  out_data.overlay_busy, out_data.level)});
        end
      end
    end
  end

  function automatic int clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  task automatic reset_mirror();
    step_q     = STEP_RESET;
    gain_q     = GAIN_RESET;
    mono_q     = 1'b0;
    ph_acc     = '0;
    ovl_active = 1'b0;
    ovl_len    = 0;
    ovl_gain_q = SCALE_RESET;
    lvl_acc    = 0;
    lvl_frames = 0;
    lvl_mean   = '0;
  endtask

  // Advance the mirror by one accepted item; a media frame queues its result.
  task automatic predict_item(input in_item_t it);
    int          l;
    int          r;
    int          ofs;
    int          al;
    int          ar;
    int unsigned rd;
    out_item_t   res;
    case (it.kind)
      KIND_WRITE: begin
        ovl_mem[it.store_index]     = it.store_value;
        ovl_written[it.store_index] = 1'b1;
      end
      KIND_START: begin
        // A zero length leaves everything as it was.
        if (it.overlay_length != 0) begin
          ovl_len    = (it.overlay_length > OVERLAY_DEPTH) ? OVERLAY_DEPTH
                                                           : it.overlay_length;
          ovl_gain_q = it.overlay_gain;
          ph_acc     = '0;
          ovl_active = 1'b1;
        end
      end
      KIND_STOP: begin
        ovl_active = 1'b0;
      end
      default: begin
        l = $signed(it.in_left);
        r = mono_q ? l : $signed(it.in_right);
        // Overlay mix; the frame that reaches the end is left unmixed.
        if (ovl_active) begin
          rd = ph_acc[31:16];
          if (rd >= ovl_len) begin
            ovl_active = 1'b0;
          end else begin
            ofs    = int'((longint'(ovl_mem[rd]) * longint'(ovl_gain_q)) >>> OVL_SHIFT);
            l      = clamp16(longint'(l + ofs));
            r      = clamp16(longint'(r + ofs));
            ph_acc = ph_acc + step_q;
          end
        end
        al = clamp16((longint'(l) * longint'(gain_q)) >>> GAIN_SHIFT);
        ar = clamp16((longint'(r) * longint'(gain_q)) >>> GAIN_SHIFT);
        // Level meter over the amplified left channel.
        lvl_acc = lvl_acc + ((al < 0) ? -al : al);
        lvl_frames++;
        if (lvl_frames >= LEVEL_WINDOW) begin
          lvl_mean   = 16'(lvl_acc / LEVEL_WINDOW);
          lvl_acc    = 0;
          lvl_frames = 0;
        end
        res.out_left     = 16'(al);
        res.out_right    = 16'(ar);
        res.overlay_busy = ovl_active;
        res.level        = lvl_mean;
        expected_frames.push_back(res);
      end
    endcase
  endtask

  // Hold the input low, wait for every expected beat, then let the pipe empty.
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP: step_q = val;
      CFG_GAIN: gain_q = val[7:0];
      CFG_MONO: mono_q = val[0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic set_config(input logic [31:0] step, input logic [7:0] gain, input bit mono);
    write_reg(CFG_STEP, step);
    write_reg(CFG_GAIN, {24'($urandom), gain});
    write_reg(CFG_MONO, {31'($urandom), mono});
  endtask

  // Send one item beat, with an optional random gap ahead of it.
  task automatic push_item(input in_item_t it);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    if (!in_valid) in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_item(it);
  endtask

  // Fields that the kind does not use are filled with junk.
  function automatic in_item_t blank_item(input kind_t k);
    in_item_t it;
    it.kind           = k;
    it.in_left        = 16'($urandom);
    it.in_right       = 16'($urandom);
    it.store_index    = IDX_W'($urandom);
    it.store_value    = 16'($urandom);
    it.overlay_length = LEN_W'($urandom);
    it.overlay_gain   = 8'($urandom);
    return it;
  endfunction

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_write(input int idx, input int val);
    in_item_t it;
    it             = blank_item(KIND_WRITE);
    it.store_index = IDX_W'(idx);
    it.store_value = 16'(val);
    push_item(it);
  endtask

  task automatic send_start(input int len, input int gain);
    in_item_t it;
    it                = blank_item(KIND_START);
    it.overlay_length = LEN_W'(len);
    it.overlay_gain   = 8'(gain);
    push_item(it);
  endtask

  task automatic send_stop();
    push_item(blank_item(KIND_STOP));
  endtask

  // A frame that would read a store entry never written gets one written first.
  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r);
    in_item_t it;
    if (ovl_active && ph_acc[31:16] < ovl_len && !ovl_written[ph_acc[31:16]]) begin
      send_write(int'(ph_acc[31:16]), int'($urandom));
    end
    it          = blank_item(KIND_FRAME);
    it.in_left  = l;
    it.in_right = r;
    push_item(it);
  endtask

  // Mostly frames, with writes, starts and stops mixed in. Ignored
  // commands do not count toward the total.
  task automatic run_random_items(input int unsigned count);
    int unsigned done;
    int          pick;
    int          len;
    bit          ignored;
    done = 0;
    while (done < count) begin
      pick    = $urandom_range(0, 99);
      ignored = 1'b0;
      if (pick < 70) begin
        send_frame(random_sample(), random_sample());
      end else if (pick < 84) begin
        send_write(int'($urandom_range(0, OVERLAY_DEPTH - 1)), int'($urandom));
      end else if (pick < 94) begin
        if ($urandom_range(0, 3) == 0) len = int'($urandom_range(0, 32767));
        else len = int'($urandom_range(1, 96));
        ignored = (len == 0);
        send_start(len, int'($urandom_range(0, 255)));
      end else begin
        ignored = !ovl_active;
        send_stop();
      end
      if (!ignored) done++;
    end
  endtask

  task automatic run_phase(input logic [31:0] step, input logic [7:0] gain, input bit mono,
                           input int unsigned count);
    set_config(step, gain, mono);
    run_random_items(count);
  endtask

  // Unity gain after reset; a write to the spare index changes nothing.
  task automatic test_reset_defaults();
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'sh7fff, 16'sh8000);
    write_reg(CFG_NONE, $urandom);
    send_frame(16'shffff, 16'sh0001);
    send_frame(16'sh8000, 16'sh7fff);
  endtask

  // Master gain at its top, at zero and at one step, with negative floors.
  task automatic test_gain_extremes();
    set_config(STEP_RESET, 8'd255, 1'b0);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'shffff, 16'sh0001);
    send_frame(16'sd300, -16'sd300);
    set_config(STEP_RESET, 8'd0, 1'b0);
    send_frame(random_sample(), random_sample());
    set_config(STEP_RESET, 8'd1, 1'b0);
    send_frame(16'sh8000, 16'sd63);
  endtask

  // Mix saturation, overlay end, idle stop, zero length, restart, active stop.
  task automatic test_overlay_sequencing();
    set_config(STEP_RESET, GAIN_RESET, 1'b0);
    send_write(0, 32767);
    send_write(1, -32768);
    send_write(2, -1);
    send_write(3, 1000);
    send_write(OVERLAY_DEPTH - 1, -5);
    send_start(3, 255);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sd100);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'sd5, 16'sd5);
    send_stop();
    send_start(0, 99);
    send_frame(16'sd7, 16'sd7);
    send_start(4, 128);
    send_frame(16'sd1, 16'sd1);
    send_start(2, 0);
    send_frame(16'sd100, -16'sd100);
    send_frame(random_sample(), random_sample());
    send_frame(random_sample(), random_sample());
    send_start(4, 200);
    send_frame(random_sample(), random_sample());
    send_stop();
    send_frame(random_sample(), random_sample());
  endtask

  // Lengths above the store depth are held at the depth.
  task automatic test_overlong_start();
    set_config(32'h4000_0000, GAIN_RESET, 1'b0);
    send_start(32767, 200);
    send_frame(random_sample(), random_sample());
    send_frame(random_sample(), random_sample());
    set_config(32'h3fff_0000, GAIN_RESET, 1'b0);
    send_start(20000, 77);
    send_frame(random_sample(), random_sample());
    send_frame(random_sample(), random_sample());
    send_frame(random_sample(), random_sample());
  endtask

  // Left copied onto right while an overlay plays.
  task automatic test_mono_source();
    set_config(STEP_RESET, 8'd96, 1'b1);
    send_start(8, 180);
    repeat (4) send_frame(random_sample(), random_sample());
  endtask

  // Random traffic under a sweep of steps and gains.
  task automatic test_random_sweep();
    run_phase(STEP_RESET, GAIN_RESET, 1'b0, 200);
    run_phase(32'h0000_8000, 8'd255, 1'b1, 200);
    run_phase(32'h0002_8000, 8'd0, 1'b0, 150);
    set_config($urandom, 8'($urandom), 1'($urandom));
    run_random_items(100);
    // The sender holds off here until every result beat has come back.
    drain_results();
    run_random_items(100);
    run_phase(32'hffff_ffff, 8'd128, 1'b0, 150);
    run_phase(32'h0000_0000, 8'd1, 1'b1, 150);
    run_phase(32'h0000_0001, 8'd200, 1'b0, 150);
  endtask

  // A whole window of saturated negative left samples gives the top level.
  // At a gain of 255, a left input of -8224 or below saturates after the gain.
  task automatic test_full_scale_level();
    set_config(STEP_RESET, 8'd255, 1'b0);
    send_stop();
    repeat ((LEVEL_WINDOW - lvl_frames) % LEVEL_WINDOW + LEVEL_WINDOW) begin
      send_frame(16'(-int'($urandom_range(8224, 32768))), random_sample());
    end
    repeat (4) send_frame(random_sample(), random_sample());
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_final_stretch();
    idle_on = 1'b0;
    set_config(32'h0001_4000, 8'($urandom), 1'($urandom));
    run_random_items(200);
  endtask

  initial begin
    reset_mirror();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_gain_extremes();
    test_overlay_sequencing();
    test_overlong_start();
    test_mono_source();
    test_random_sweep();
    test_full_scale_level();
    test_final_stretch();

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== pcm_overlay_mixer_level_meter_unit.f =====
rtl/core/pomlm_pkg.sv
rtl/core/pomlm_ctrl.sv
rtl/core/pomlm_dp.sv
rtl/core/pcm_overlay_mixer_level_meter_unit.sv
bench/pcm_overlay_mixer_level_meter_unit_test.sv
